### hdl/bcbs_pkg.sv
package bcbs_pkg;

  localparam int POS_W   = 16;
  localparam int VEL_W   = 16;
  localparam int RAD_W   = 8;
  localparam int AREA_W  = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [AREA_W-1:0] AREA_W_RESET = 12'd800;
  localparam logic [AREA_W-1:0] AREA_H_RESET = 12'd600;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider: the numerator magnitude stays below 2^46, a touching pair has a
  // squared distance below 2^26, and the quotient stays below 2^18.
  localparam int DIV_NUM_W = 46;
  localparam int DIV_DEN_W = 27;
  localparam int DIV_Q_W   = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_WIDTH  = 2'd0,
    REG_AREA_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef struct packed {
    logic                    action;
    logic [2:0]              ball_index;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [RAD_W-1:0]        radius;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [15:0]             step_time;
  } item_t;

  typedef struct packed {
    logic [2:0]              out_index;
    logic [POS_W-1:0]        out_x;
    logic [POS_W-1:0]        out_y;
    logic signed [VEL_W-1:0] out_vx;
    logic signed [VEL_W-1:0] out_vy;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0]        x;
    logic [POS_W-1:0]        y;
    logic [RAD_W-1:0]        r;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } ball_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RDI, S_RDJ, S_GETJ, S_DIFF, S_DX2, S_DY2, S_RS2, S_TEST,
    S_SX, S_SY, S_SUM, S_CX, S_STX, S_DVX, S_CY, S_STY, S_DVY,
    S_WRI, S_WRJ, S_NEXT, S_MRD, S_MGET, S_MVX, S_MVY, S_MRND, S_MWB
  } state_t;

  function automatic logic signed [VEL_W-1:0] sat16(input logic signed [20:0] v);
    logic signed [VEL_W-1:0] res;
    if (v > 21'sd32767) res = 16'sh7fff;
    else if (v < -21'sd32768) res = 16'sh8000;
    else res = v[VEL_W-1:0];
    return res;
  endfunction

  function automatic logic signed [VEL_W-1:0] abs_sat(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W-1:0] res;
    if (v == 16'sh8000) res = 16'sh7fff;
    else if (v < 0) res = -v;
    else res = v;
    return res;
  endfunction

  // Product divided by 2^16, rounded to nearest with ties away from zero.
  function automatic logic signed [17:0] round_q16(input logic signed [MUL_P_W-1:0] p);
    logic [MUL_P_W-1:0] m;
    logic [32:0]        q;
    m = p[MUL_P_W-1] ? $unsigned(-p) : $unsigned(p);
    q = (m[32:0] + 33'd32768) >> 16;
    return p[MUL_P_W-1] ? -18'(q[16:0]) : 18'(q[16:0]);
  endfunction

endpackage

### hdl/bcbs_if.sv
interface bcbs_item_if
  import bcbs_pkg::*;
;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bcbs_result_if
  import bcbs_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bcbs_cfg_if
  import bcbs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [AREA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/bcbs_mul.sv
module bcbs_mul
  import bcbs_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

### hdl/bcbs_div.sv
module bcbs_div
  import bcbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int SH_W  = DIV_DEN_W + DIV_Q_W - 1;
  localparam int CNT_W = $clog2(DIV_Q_W);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_NUM_W-1:0] rem;
  logic [SH_W-1:0]      dsh;
  logic [DIV_Q_W-1:0]   quo;
  logic                 fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign fits = (DIV_NUM_W'(dsh) <= rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= SH_W'(req.den) << (DIV_Q_W - 1);
      quo <= '0;
      cnt <= CNT_W'(DIV_Q_W - 1);
    end else if (busy) begin
      if (fits) rem <= rem - DIV_NUM_W'(dsh);
      quo <= {quo[DIV_Q_W-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

### hdl/ball_collision_bounce_step.sv
// Load item: written to the ball memory when taken; the block stays idle and ready.
// Step item: every pair is tested for contact, a touching pair takes two divisions,
// then each ball is moved and its result sent; the shared multiplier, the divider and
// the ball memory with one read port and one write port serialise this work.
// One item at a time; a result may still wait while the next item is taken.
// Reset restores the area size and idles the sequencer; the ball memory is not cleared.
module ball_collision_bounce_step
  import bcbs_pkg::*;
#(
  parameter int BALL_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst,
  bcbs_item_if.sink       items,
  bcbs_result_if.source   results,
  bcbs_cfg_if.sink        cfg
);

  localparam int IDX_W = (BALL_COUNT > 2) ? $clog2(BALL_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BALL_COUNT - 1);

  state_t state, state_next;

  logic [AREA_W-1:0] area_w, area_h;

  ball_t mem [BALL_COUNT];
  ball_t rdata;
  logic  mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  ball_t mem_wdata;

  logic [IDX_W-1:0] i, j;
  ball_t ba, bb;
  logic [15:0] step_t;
  logic signed [16:0] dx, dy;
  logic [12:0] rs;
  logic [34:0] d2;
  logic signed [32:0] sacc;
  logic num_neg;
  logic signed [19:0] cx, cy;
  logic signed [17:0] mx, my;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic [MUL_P_W-1:0] prod_abs;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic    res_valid;
  result_t res_item;
  logic    adv;
  logic    take;
  logic    load_ok;
  logic    touch;

  logic signed [VEL_W-1:0] new_vxi, new_vyi, new_vxj, new_vyj;
  logic signed [18:0] x19, y19, r19, w19, h19, nx, ny;
  logic signed [VEL_W-1:0] nvx, nvy;
  ball_t moved;

  bcbs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  bcbs_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign take    = items.valid && items.ready;
  assign load_ok = (int'(items.item.ball_index) < BALL_COUNT);
  assign adv     = !res_valid || results.ready;
  assign touch   = (d2 != '0) && (d2 <= prod[34:0]);
  assign prod_abs = prod[MUL_P_W-1] ? $unsigned(-prod) : $unsigned(prod);

  assign cfg.ready     = 1'b1;
  assign results.valid = res_valid;
  assign results.item  = res_item;

  always_comb begin
    new_vxi = sat16(21'(ba.vx) - 21'(cx));
    new_vyi = sat16(21'(ba.vy) - 21'(cy));
    new_vxj = sat16(21'(bb.vx) + 21'(cx));
    new_vyj = sat16(21'(bb.vy) + 21'(cy));
  end

  // Wall tests look at the old position; top overrides bottom, left overrides right.
  always_comb begin
    x19 = 19'(ba.x);
    y19 = 19'(ba.y);
    r19 = 19'({ba.r, 4'b0});
    w19 = 19'({area_w, 4'b0});
    h19 = 19'({area_h, 4'b0});
    nx  = x19 + 19'(mx);
    ny  = y19 + 19'(my);
    nvx = ba.vx;
    nvy = ba.vy;
    if (y19 + r19 > h19) begin
      nvy = -abs_sat(ba.vy);
      ny  = h19 - r19;
    end
    if (y19 < r19) begin
      nvy = abs_sat(ba.vy);
      ny  = r19;
    end
    if (x19 + r19 > w19) begin
      nvx = -abs_sat(ba.vx);
      nx  = w19 - r19;
    end
    if (x19 < r19) begin
      nvx = abs_sat(ba.vx);
      nx  = r19;
    end
    moved.r  = ba.r;
    moved.vx = nvx;
    moved.vy = nvy;
    if (nx < 0) moved.x = '0;
    else if (nx > 19'sd65535) moved.x = 16'hffff;
    else moved.x = nx[15:0];
    if (ny < 0) moved.y = '0;
    else if (ny > 19'sd65535) moved.y = 16'hffff;
    else moved.y = ny[15:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take && items.item.action == ACT_STEP) state_next = S_RDI;
      S_RDI:  state_next = S_RDJ;
      S_RDJ:  state_next = S_GETJ;
      S_GETJ: state_next = S_DIFF;
      S_DIFF: state_next = S_DX2;
      S_DX2:  state_next = S_DY2;
      S_DY2:  state_next = S_RS2;
      S_RS2:  state_next = S_TEST;
      S_TEST: state_next = touch ? S_SX : S_NEXT;
      S_SX:   state_next = S_SY;
      S_SY:   state_next = S_SUM;
      S_SUM:  state_next = S_CX;
      S_CX:   state_next = S_STX;
      S_STX:  state_next = S_DVX;
      S_DVX:  if (div_rsp.done) state_next = S_CY;
      S_CY:   state_next = S_STY;
      S_STY:  state_next = S_DVY;
      S_DVY:  if (div_rsp.done) state_next = S_WRI;
      S_WRI:  state_next = S_WRJ;
      S_WRJ:  state_next = S_NEXT;
      S_NEXT: state_next = (j == LAST && i == LAST - 1'b1) ? S_MRD : S_RDI;
      S_MRD:  state_next = S_MGET;
      S_MGET: state_next = S_MVX;
      S_MVX:  state_next = S_MVY;
      S_MVY:  state_next = S_MRND;
      S_MRND: state_next = S_MWB;
      S_MWB:  if (adv) state_next = (i == LAST) ? S_IDLE : S_MRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    items.ready   = (state == S_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = i;
    mem_wdata     = ba;
    mem_raddr     = i;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = DIV_NUM_W'(prod_abs) + DIV_NUM_W'(d2[34:1]);
    div_req.den   = d2[DIV_DEN_W-1:0];
    unique case (state)
      S_IDLE: begin
        mem_we    = take && items.item.action == ACT_LOAD && load_ok;
        mem_waddr = IDX_W'(items.item.ball_index);
        mem_wdata = '{x: items.item.pos_x, y: items.item.pos_y, r: items.item.radius,
                      vx: items.item.vel_x, vy: items.item.vel_y};
      end
      S_RDJ: mem_raddr = j;
      S_DX2: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'(dx);
      end
      S_DY2: begin
        mul_a = MUL_A_W'(dy);
        mul_b = MUL_B_W'(dy);
      end
      S_RS2: begin
        mul_a = MUL_A_W'(rs);
        mul_b = MUL_B_W'(rs);
      end
      S_SX: begin
        mul_a = MUL_A_W'(17'(ba.vx) - 17'(bb.vx));
        mul_b = MUL_B_W'(dx);
      end
      S_SY: begin
        mul_a = MUL_A_W'(17'(ba.vy) - 17'(bb.vy));
        mul_b = MUL_B_W'(dy);
      end
      S_CX: begin
        mul_a = MUL_A_W'(dx);
        mul_b = sacc;
      end
      S_CY: begin
        mul_a = MUL_A_W'(dy);
        mul_b = sacc;
      end
      S_STX, S_STY: div_req.start = 1'b1;
      S_WRI: begin
        mem_we    = 1'b1;
        mem_wdata = '{x: ba.x, y: ba.y, r: ba.r, vx: new_vxi, vy: new_vyi};
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = '{x: bb.x, y: bb.y, r: bb.r, vx: new_vxj, vy: new_vyj};
      end
      S_MVX: begin
        mul_a = MUL_A_W'(ba.vx);
        mul_b = MUL_B_W'(step_t);
      end
      S_MVY: begin
        mul_a = MUL_A_W'(ba.vy);
        mul_b = MUL_B_W'(step_t);
      end
      S_MWB: begin
        mem_we    = adv;
        mem_wdata = moved;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      area_w    <= AREA_W_RESET;
      area_h    <= AREA_H_RESET;
      res_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_AREA_WIDTH:  area_w <= cfg.data;
          REG_AREA_HEIGHT: area_h <= cfg.data;
          default: ;
        endcase
      end
      if (state == S_MWB && adv) res_valid <= 1'b1;
      else if (results.ready) res_valid <= 1'b0;
      if (state == S_IDLE && take) begin
        i <= '0;
        j <= IDX_W'(1);
      end else if (state == S_NEXT) begin
        if (j != LAST) begin
          j <= j + 1'b1;
        end else if (i == LAST - 1'b1) begin
          i <= '0;
        end else begin
          i <= i + 1'b1;
          j <= i + IDX_W'(2);
        end
      end else if (state == S_MWB && adv && i != LAST) begin
        i <= i + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && take) step_t <= items.item.step_time;
    if (state == S_RDJ || state == S_MGET) ba <= rdata;
    if (state == S_GETJ) bb <= rdata;
    if (state == S_DIFF) begin
      dx <= 17'(ba.x) - 17'(bb.x);
      dy <= 17'(ba.y) - 17'(bb.y);
      rs <= {(9'(ba.r) + 9'(bb.r)), 4'b0};
    end
    if (state == S_DY2) d2 <= prod[34:0];
    if (state == S_RS2) d2 <= d2 + prod[34:0];
    if (state == S_SY)  sacc <= prod[32:0];
    if (state == S_SUM) sacc <= sacc + prod[32:0];
    if (state == S_STX || state == S_STY) num_neg <= prod[MUL_P_W-1];
    if (state == S_DVX && div_rsp.done)
      cx <= num_neg ? -20'(div_rsp.quo) : 20'(div_rsp.quo);
    if (state == S_DVY && div_rsp.done)
      cy <= num_neg ? -20'(div_rsp.quo) : 20'(div_rsp.quo);
    if (state == S_MVY)  mx <= round_q16(prod);
    if (state == S_MRND) my <= round_q16(prod);
    if (state == S_MWB && adv) begin
      res_item.out_index <= 3'(i);
      res_item.out_x     <= moved.x;
      res_item.out_y     <= moved.y;
      res_item.out_vx    <= moved.vx;
      res_item.out_vy    <= moved.vy;
      res_item.last      <= (i == LAST);
    end
  end

  // A pair is always read with the second ball above the first.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDI) |-> (j > i))
    else $error("pair visited out of order");

  // The collision response runs only for pairs with distinct centres.
  a_no_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (state == S_SX) |-> (d2 != '0))
    else $error("collision response on coincident centres");

  // A quotient comes back only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DVX || state == S_DVY))
    else $error("divider finished outside a wait state");

endmodule

### sim/ball_collision_bounce_step_test.sv
module ball_collision_bounce_step_test
  import bcbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBALLS = 8;

  class bounce_scoreboard;
    logic [15:0] px[NBALLS];
    logic [15:0] py[NBALLS];
    logic [7:0]  rad[NBALLS];
    longint      vx[NBALLS];
    longint      vy[NBALLS];
    longint      area_w;
    longint      area_h;
    result_t     expected_balls[$];
    int          errors;
    int          results_seen;

    function new();
      area_w = 800;
      area_h = 600;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [AREA_W-1:0] value);
      if (idx == REG_AREA_WIDTH) area_w = value;
      else if (idx == REG_AREA_HEIGHT) area_h = value;
    endfunction

    function longint sat_vel(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Rounds to nearest, ties away from zero.
    function longint round_div(longint num, longint den);
      longint m;
      longint q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function longint mag_sat(longint v);
      return (v < 0) ? sat_vel(-v) : v;
    endfunction

    function longint clamp_pos(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
    endfunction

    function void collide_pair(int i, int j);
      longint dx, dy, d2, rs, s, cx, cy;
      dx = longint'(px[i]) - longint'(px[j]);
      dy = longint'(py[i]) - longint'(py[j]);
      d2 = dx * dx + dy * dy;
      rs = 16 * (longint'(rad[i]) + longint'(rad[j]));
      if (d2 == 0 || d2 > rs * rs) return;
      s = (vx[i] - vx[j]) * dx + (vy[i] - vy[j]) * dy;
      cx = round_div(dx * s, d2);
      cy = round_div(dy * s, d2);
      vx[i] = sat_vel(vx[i] - cx);
      vy[i] = sat_vel(vy[i] - cy);
      vx[j] = sat_vel(vx[j] + cx);
      vy[j] = sat_vel(vy[j] + cy);
    endfunction

    function void move_ball(int i, longint t);
      longint x, y, r, w, h, nx, ny;
      x = px[i];
      y = py[i];
      r = 16 * longint'(rad[i]);
      w = 16 * area_w;
      h = 16 * area_h;
      nx = x + round_div(vx[i] * t, 65536);
      ny = y + round_div(vy[i] * t, 65536);
      // Wall tests look at the old position; top wins over bottom, left over right.
      if (y + r > h) begin vy[i] = -mag_sat(vy[i]); ny = h - r; end
      if (y < r) begin vy[i] = mag_sat(vy[i]); ny = r; end
      if (x + r > w) begin vx[i] = -mag_sat(vx[i]); nx = w - r; end
      if (x < r) begin vx[i] = mag_sat(vx[i]); nx = r; end
      px[i] = 16'(clamp_pos(nx));
      py[i] = 16'(clamp_pos(ny));
    endfunction

    function void note_item(item_t it);
      result_t res;
      int k;
      if (it.action == ACT_LOAD) begin
        k = it.ball_index;
        px[k] = it.pos_x;
        py[k] = it.pos_y;
        rad[k] = it.radius;
        vx[k] = longint'($signed(it.vel_x));
        vy[k] = longint'($signed(it.vel_y));
        return;
      end
      for (int i = 0; i < NBALLS; i++)
        for (int j = i + 1; j < NBALLS; j++)
          collide_pair(i, j);
      for (int i = 0; i < NBALLS; i++) begin
        move_ball(i, longint'(it.step_time));
        res.out_index = 3'(i);
        res.out_x = px[i];
        res.out_y = py[i];
        res.out_vx = 16'(vx[i]);
        res.out_vy = 16'(vy[i]);
        res.last = (i == NBALLS - 1);
        expected_balls.push_back(res);
      end
    endfunction

    function void compare_field(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      results_seen++;
      if (expected_balls.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %p", $realtime, got);
        errors++;
        return;
      end
      e = expected_balls.pop_front();
      compare_field("out_index", e.out_index, got.out_index);
      compare_field("out_x", e.out_x, got.out_x);
      compare_field("out_y", e.out_y, got.out_y);
      compare_field("out_vx", $signed(e.out_vx), $signed(got.out_vx));
      compare_field("out_vy", $signed(e.out_vy), $signed(got.out_vy));
      compare_field("last", e.last, got.last);
    endfunction

    function int pending();
      return expected_balls.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bcbs_item_if   items_if();
  bcbs_result_if results_if();
  bcbs_cfg_if    cfg_if();

  ball_collision_bounce_step #(.BALL_COUNT(NBALLS)) DUT (
    .clk(clk),
    .rst(rst),
    .items(items_if),
    .results(results_if),
    .cfg(cfg_if)
  );

  always #6 clk = ~clk;

  bounce_scoreboard sb = new();
  bit hold_request = 1'b0;
  int burst_left = 0;
  int load_count = 0;
  int step_count = 0;
  longint center_x, center_y;

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  // Receiver: stalls on its own changing pattern, with one long hold-off on request.
  initial begin
    int cyc;
    int hold_left;
    bit take;
    result_t cap;
    cyc = 0;
    hold_left = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      take = results_if.valid && results_if.ready;
      cap = results_if.item;
      @(posedge clk);
      if (take) sb.check_result(cap);
      cyc++;
      if (hold_request && hold_left == 0) begin
        hold_left = 3000;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        case ((cyc / 300) % 4)
          0: results_if.ready <= 1'b1;
          1: results_if.ready <= ($urandom_range(0, 1) == 1);
          2: results_if.ready <= ($urandom_range(0, 5) == 0);
          default: results_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_item(item_t it);
    bit acc;
    items_if.item <= it;
    items_if.valid <= 1'b1;
    do begin
      @(negedge clk);
      acc = items_if.ready;
      @(posedge clk);
    end while (!acc);
    sb.note_item(it);
    if (it.action == ACT_LOAD) load_count++;
    else step_count++;
    burst_left--;
    if (burst_left <= 0) begin
      int gap;
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_ball(int k, longint x, longint y, int r, longint vxl, longint vyl);
    item_t it;
    it = item_t'($urandom_range(0, 1) ? {$urandom, $urandom, $urandom} : '0);
    it.action = ACT_LOAD;
    it.ball_index = 3'(k);
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    it.radius = 8'(r);
    it.vel_x = 16'(vxl);
    it.vel_y = 16'(vyl);
    send_item(it);
  endtask

  task automatic step_balls(int t);
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom});
    it.action = ACT_STEP;
    it.step_time = 16'(t);
    send_item(it);
  endtask

  // Drains all expected results, then lets a trailing load finish before a write.
  task automatic wait_idle();
    items_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [AREA_W-1:0] value);
    bit acc;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    cfg_if.valid <= 1'b1;
    do begin
      @(negedge clk);
      acc = cfg_if.ready;
      @(posedge clk);
    end while (!acc);
    cfg_if.valid <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  function automatic longint near_center(longint c);
    longint v;
    v = c + longint'($urandom_range(0, 6000)) - 3000;
    return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
  endfunction

  function automatic longint rand_vel();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 65535)) - 32768;
      1: return ($urandom_range(0, 1)) ? 32767 : -32768;
      default: return longint'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic int rand_time();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  initial begin
    logic [AREA_W-1:0] widths[6];
    logic [AREA_W-1:0] heights[6];
    widths  = '{12'd800, 12'd4095, 12'd1, 12'd300, 12'd4095, 12'd2000};
    heights = '{12'd600, 12'd4095, 12'd1, 12'd4095, 12'd200, 12'd1500};
    rst <= 1'b1;
    items_if.valid <= 1'b0;
    items_if.item <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_AREA_WIDTH;
    cfg_if.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, a coincident pair, a touching pair, and every wall.
    load_ball(0, 0, 0, 255, -32768, -32768);
    load_ball(1, 65535, 65535, 0, 32767, 32767);
    load_ball(2, 4000, 4000, 50, 1000, 0);
    load_ball(3, 4000, 4000, 50, -1000, 0);
    load_ball(4, 5000, 4100, 40, -3000, 500);
    load_ball(5, 100, 3000, 20, -500, 200);
    load_ball(6, 12700, 9500, 30, 700, 900);
    load_ball(7, 6000, 100, 10, 100, -32768);
    step_balls(65535);
    step_balls(0);
    load_ball(0, 200, 200, 0, 0, 0);
    load_ball(1, 200, 200, 0, 32767, -32768);
    step_balls(30000);
    step_balls(1);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(REG_AREA_WIDTH, widths[p]);
      write_reg(REG_AREA_HEIGHT, heights[p]);
      center_x = $urandom_range(0, 65535);
      center_y = $urandom_range(0, 65535);
      if (p == 2) hold_request = 1'b1;
      for (int n = 0; n < 56; n++) begin
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
          load_ball($urandom_range(0, 7), near_center(center_x), near_center(center_y),
                    $urandom_range(10, 200), rand_vel(), rand_vel());
        else if (sel < 80)
          step_balls(rand_time());
        else
          load_ball($urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 255), rand_vel(), rand_vel());
      end
      step_balls(rand_time());
    end

    items_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d loads and %0d steps over six area sizes, %0d ball results checked.",
             load_count, step_count, sb.results_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
